FILE: src/gtht_pkg.sv
// ============================================================================
// gtht_pkg
// Shared types, constants and codes for the generation-tagged handle table.
// ============================================================================
package gtht_pkg;

    localparam int SLOT_COUNT_DEF      = 256;
    localparam int GENERATION_BITS_DEF = 23;
    localparam int OWNER_BITS_DEF      = 16;

    localparam int ACTION_W  = 3;
    localparam int ID_W      = 16;
    localparam int HANDLE_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int HOUT_W    = 31;
    localparam int SIDX_W    = 8;
    localparam int COUNT_W   = 9;
    localparam int LIMIT_W   = 9;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd64;

    localparam logic [ACTION_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_OWNER  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TARGET = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]        action;
        logic [ID_W-1:0]            owner_id;
        logic [ID_W-1:0]            target_id;
        logic signed [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HOUT_W-1:0]   handle_out;
        logic [SIDX_W-1:0]   slot_index;
        logic [ID_W-1:0]     slot_target;
        logic [COUNT_W-1:0]  freed_count;
    } rsp_t;

endpackage

FILE: src/gtht_req_if.sv
// ============================================================================
// gtht_req_if
// Valid/ready channel carrying one request.
// ============================================================================
interface gtht_req_if;
    logic            valid;
    logic            ready;
    gtht_pkg::req_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/gtht_rsp_if.sv
// ============================================================================
// gtht_rsp_if
// Valid/ready channel carrying one response.
// ============================================================================
interface gtht_rsp_if;
    logic            valid;
    logic            ready;
    gtht_pkg::rsp_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/gtht_ram.sv
// ============================================================================
// gtht_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module gtht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/generation_tagged_handle_table.sv
// ============================================================================
// generation_tagged_handle_table
// Slot table that issues generation-tagged handles, one slot scanned a cycle.
//
//   channel | dir | contents
//   --------+-----+------------------------------------------------------
//   req     | in  | action, owner_id, target_id, handle_in
//   rsp     | out | status, handle_out, slot_index, slot_target, freed_count
//   cfg     | in  | owner_limit write (cfg_we, cfg_wdata)
//
// After reset a clearing pass writes every slot before the first request transfer.
// Create and sweeps read one slot per cycle from the slot RAM; sweeps clear each
// matching entry as it is scanned and create then read-modify-writes the chosen
// free slot. Lookup reads the handle's slot, delete read-modify-writes it and an
// unused action responds directly. One request is in flight; the response register
// holds while the sink stalls and the next request is not taken until it is drained.
// ============================================================================
module generation_tagged_handle_table #(
    parameter int SLOT_COUNT      = gtht_pkg::SLOT_COUNT_DEF,
    parameter int GENERATION_BITS = gtht_pkg::GENERATION_BITS_DEF,
    parameter int OWNER_BITS      = gtht_pkg::OWNER_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [gtht_pkg::LIMIT_W-1:0] cfg_wdata,
    gtht_req_if.sink                     req,
    gtht_rsp_if.source                   rsp
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int EW = 1 + OWNER_BITS + gtht_pkg::ID_W + GENERATION_BITS;
    localparam int CW = AW + 1;
    localparam int FW = GENERATION_BITS + AW;
    localparam int HANDLE_W_L = gtht_pkg::HANDLE_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_RMW   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    typedef struct packed {
        logic                       valid;
        logic [OWNER_BITS-1:0]      owner;
        logic [gtht_pkg::ID_W-1:0]  target;
        logic [GENERATION_BITS-1:0] gen;
    } entry_t;

    logic [2:0]                  state_reg, state_next;
    logic [gtht_pkg::LIMIT_W-1:0] limit_reg;
    gtht_pkg::req_t              req_reg;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [AW-1:0]               prev_reg;
    logic                        found_reg;
    logic [AW-1:0]               free_reg;
    logic [CW-1:0]               owned_reg;
    logic [gtht_pkg::COUNT_W-1:0] freed_reg;
    gtht_pkg::rsp_t              rsp_reg;

    logic           wr_en;
    logic [AW-1:0]  wr_addr, rd_addr;
    entry_t         wr_data, rd_data;

    gtht_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [OWNER_BITS-1:0] own_in;
    logic [HANDLE_W_L-1:0] hsl;
    logic [AW-1:0]         hslot;
    logic                  hit;
    logic                  owned_ok;
    logic [GENERATION_BITS-1:0] gen_inc;
    logic [FW-1:0]         full_new, full_cur;
    logic [63:0]           full_cur64, h64;
    logic                  match;

    assign own_in  = OWNER_BITS'(req_reg.owner_id);
    assign hsl     = req_reg.handle_in;
    assign hslot   = hsl[AW-1:0];
    assign req.ready = (state_reg == S_IDLE) && !rsp.valid;
    assign rsp.payload = rsp_reg;

    // hit for the entry returned this cycle (scan address prev_reg)
    always_comb
    begin
        hit = 1'b0;
        if (req_reg.action == gtht_pkg::ACT_OWNER)
        begin
            hit = rd_data.valid && rd_data.owner == own_in;
        end
        else if (req_reg.action == gtht_pkg::ACT_TARGET)
        begin
            hit = req_reg.target_id != '0 && rd_data.valid
                  && rd_data.target == req_reg.target_id;
        end
    end

    assign gen_inc  = (rd_data.gen + 1'b1 == '0) ? GENERATION_BITS'(1) : rd_data.gen + 1'b1;
    assign full_new = {gen_inc, free_reg};
    assign full_cur = {rd_data.gen, hslot};
    assign full_cur64 = 64'(full_cur);
    assign h64        = 64'(hsl);
    assign match = !hsl[HANDLE_W_L-1] && rd_data.valid && rd_data.owner == own_in
                   && full_cur64 == h64;
    assign owned_ok = 32'(owned_reg) < 32'(limit_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rd_addr    = cnt_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = prev_reg;
        wr_data    = rd_data;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[AW-1:0];
                wr_data = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = '0;
                if (req.valid && req.ready)
                begin
                    if (req.payload.action == gtht_pkg::ACT_LOOKUP
                        || req.payload.action == gtht_pkg::ACT_DELETE)
                    begin
                        rd_addr    = req.payload.handle_in[AW-1:0];
                        state_next = S_RMW;
                    end
                    else if (req.payload.action == gtht_pkg::ACT_CREATE
                             || req.payload.action == gtht_pkg::ACT_OWNER
                             || req.payload.action == gtht_pkg::ACT_TARGET)
                    begin
                        cnt_next   = CW'(1);
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    wr_en   = 1'b1;
                    wr_data = '{valid: 1'b0, owner: '0, target: '0, gen: rd_data.gen};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SLOT_COUNT))
                begin
                    rd_addr    = free_reg;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // reissue the read of the chosen free slot now that the last scanned entry has updated free_reg
                rd_addr = free_reg;
                state_next = S_RMW;
            end
            S_RMW:
            begin
                if (req_reg.action == gtht_pkg::ACT_CREATE)
                begin
                    wr_addr = free_reg;
                    if (found_reg && owned_ok)
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{valid: 1'b1, owner: own_in,
                                    target: req_reg.target_id, gen: gen_inc};
                    end
                end
                else if (req_reg.action == gtht_pkg::ACT_DELETE)
                begin
                    wr_addr = hslot;
                    if (match)
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{valid: 1'b0, owner: '0, target: '0, gen: rd_data.gen};
                    end
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            limit_reg <= gtht_pkg::LIMIT_RESET;
            rsp.valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (rsp.valid && rsp.ready)
            begin
                rsp.valid <= 1'b0;
            end
            if (state_reg == S_RESP)
            begin
                rsp.valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= rd_addr;
        if (state_reg == S_IDLE && req.valid && req.ready)
        begin
            req_reg   <= req.payload;
            found_reg <= 1'b0;
            free_reg  <= '0;
            owned_reg <= '0;
            freed_reg <= '0;
            rsp_reg   <= '0;
        end
        if (state_reg == S_SCAN)
        begin
            if (!rd_data.valid && !found_reg)
            begin
                found_reg <= 1'b1;
                free_reg  <= prev_reg;
            end
            if (rd_data.valid && rd_data.owner == own_in)
            begin
                owned_reg <= owned_reg + 1'b1;
            end
            if (hit && freed_reg != '1)
            begin
                freed_reg <= freed_reg + 1'b1;
            end
        end
        if (state_reg == S_RMW)
        begin
            unique case (req_reg.action)
                gtht_pkg::ACT_CREATE:
                begin
                    if (found_reg && owned_ok)
                    begin
                        rsp_reg.handle_out <= gtht_pkg::HOUT_W'(64'(full_new));
                        rsp_reg.slot_index <= gtht_pkg::SIDX_W'(free_reg);
                    end
                    else
                    begin
                        rsp_reg.status <= gtht_pkg::ST_FULL;
                    end
                end
                gtht_pkg::ACT_LOOKUP:
                begin
                    if (match)
                    begin
                        rsp_reg.handle_out  <= hsl[gtht_pkg::HOUT_W-1:0];
                        rsp_reg.slot_index  <= gtht_pkg::SIDX_W'(hslot);
                        rsp_reg.slot_target <= rd_data.target;
                    end
                    else
                    begin
                        rsp_reg.status <= gtht_pkg::ST_INVALID;
                    end
                end
                gtht_pkg::ACT_DELETE:
                begin
                    if (match)
                    begin
                        rsp_reg.slot_index  <= gtht_pkg::SIDX_W'(hslot);
                        rsp_reg.freed_count <= gtht_pkg::COUNT_W'(1);
                    end
                    else
                    begin
                        rsp_reg.status <= gtht_pkg::ST_INVALID;
                    end
                end
                default:
                begin
                    rsp_reg.freed_count <= freed_reg;
                end
            endcase
        end
    end

endmodule

FILE: src/gtht_checker.sv
// ============================================================================
// gtht_assertions
// Port-level checks for the handle table, bound to the top level.
// ============================================================================
module gtht_assertions (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input gtht_pkg::rsp_t rsp_payload
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("response dropped or changed under stall");

    a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while response pending");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken back to back");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_payload.status <= gtht_pkg::ST_FULL)
        else $error("unknown status code");

    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.status != gtht_pkg::ST_OK
        |-> rsp_payload.handle_out == '0 && rsp_payload.freed_count == '0)
        else $error("error response carries data");

endmodule

bind generation_tagged_handle_table gtht_assertions u_gtht_assertions (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
